### rtl/fes_pkg.sv
package fes_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned FRAC_W  = 23;
    localparam int unsigned EXP_W   = 8;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned LZ_W    = 5;
    // wide enough for biased exponent plus any scale amount
    localparam int unsigned SUM_W   = 17;

    localparam logic [EXP_W-1:0] EXP_MAX = 8'hff;

    typedef logic [WORD_W-1:0]         t_word;
    typedef logic signed [SCALE_W-1:0] t_scale;

    typedef enum logic [1:0] {
        CLS_ZERO   = 2'd0,
        CLS_FINITE = 2'd1,
        CLS_INF    = 2'd2,
        CLS_NAN    = 2'd3
    } t_class;

    // leading zeros of the fraction field, counted from bit 22
    function automatic logic [LZ_W-1:0] lead_zeros(input logic [FRAC_W-1:0] f);
        logic [LZ_W-1:0] n;
        logic            found;
        n     = '0;
        found = 1'b0;
        for (int i = FRAC_W - 1; i >= 0; i--) begin
            if (!found) begin
                if (f[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 1'b1;
                end
            end
        end
        return n;
    endfunction

endpackage

### rtl/fes_if.sv
interface fes_in_if;
    logic            valid;
    logic            ready;
    fes_pkg::t_word  value_bits;
    fes_pkg::t_scale scale_amount;

    modport source (output valid, output value_bits, output scale_amount, input ready);
    modport sink   (input valid, input value_bits, input scale_amount, output ready);
endinterface

interface fes_out_if;
    logic            valid;
    logic            ready;
    fes_pkg::t_word  result_bits;
    fes_pkg::t_class result_class;

    modport source (output valid, output result_bits, output result_class, input ready);
    modport sink   (input valid, input result_bits, input result_class, output ready);
endinterface

### rtl/float32_exponent_scale_top.sv
// channel   | dir | word
// ----------+-----+---------------------------------------------
// i_in_ch   | in  | value_bits[31:0], scale_amount[15:0] signed
// o_out_ch  | out | result_bits[31:0], result_class[1:0]
//
// three register stages: classify and leading-zero count, normalize and
// exponent add, saturate and pack. one word per cycle while o_out_ch does not stall.
// each stage moves when it is empty or the stage after it moves, so a stall
// on o_out_ch backs up stage by stage with nothing dropped or repeated.
// i_rst_n (synchronous, active low) clears the stage valid bits only.
module float32_exponent_scale_top (
    input  logic i_clk,
    input  logic i_rst_n,
    fes_in_if.sink    i_in_ch,
    fes_out_if.source o_out_ch
);
    import fes_pkg::*;

    // stage enables
    logic en1, en2, en3;

    // stage 1: classify
    logic                r1_valid;
    t_word               r1_word;
    t_scale              r1_scale;
    logic                r1_special;
    t_class              r1_cls;
    logic                r1_sub;
    logic [LZ_W-1:0]     r1_lz;

    // stage 2: normalize and add
    logic                r2_valid;
    logic                r2_sign;
    t_word               r2_word;
    logic                r2_special;
    t_class              r2_cls;
    logic [FRAC_W-1:0]   r2_frac;
    logic signed [SUM_W-1:0] r2_newexp;

    // stage 3: output register
    logic                r3_valid;
    t_word               r3_res;
    t_class              r3_cls;

    logic [EXP_W-1:0]    s1_exp;
    logic [FRAC_W-1:0]   s1_frac;
    logic                n1_special;
    t_class              n1_cls;

    logic [FRAC_W:0]     s2_shifted;
    logic signed [EXP_W:0] s2_exp;
    logic signed [SUM_W-1:0] n2_newexp;
    logic [FRAC_W-1:0]   n2_frac;

    t_word               n3_res;
    t_class              n3_cls;

    assign en3 = !r3_valid || o_out_ch.ready;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign i_in_ch.ready = en1;

    assign s1_exp  = i_in_ch.value_bits[WORD_W-2:FRAC_W];
    assign s1_frac = i_in_ch.value_bits[FRAC_W-1:0];

    always_comb begin
        n1_special = 1'b1;
        n1_cls     = CLS_FINITE;
        if (s1_exp == EXP_MAX) begin
            n1_cls = (s1_frac != '0) ? CLS_NAN : CLS_INF;
        end else if (i_in_ch.value_bits[WORD_W-2:0] == '0) begin
            n1_cls = CLS_ZERO;
        end else begin
            n1_special = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_in_ch.valid;
        end
        if (en1) begin
            r1_word    <= i_in_ch.value_bits;
            r1_scale   <= i_in_ch.scale_amount;
            r1_special <= n1_special;
            r1_cls     <= n1_cls;
            r1_sub     <= (s1_exp == '0);
            r1_lz      <= lead_zeros(s1_frac);
        end
    end

    // subnormal: shift until the hidden bit sits at bit 23, exponent is -lz
    assign s2_shifted = {r1_word[FRAC_W-1:0], 1'b0} << r1_lz;

    always_comb begin
        if (r1_sub) begin
            s2_exp  = -$signed({{(EXP_W + 1 - LZ_W){1'b0}}, r1_lz});
            n2_frac = s2_shifted[FRAC_W-1:0];
        end else begin
            s2_exp  = $signed({1'b0, r1_word[WORD_W-2:FRAC_W]});
            n2_frac = r1_word[FRAC_W-1:0];
        end
        n2_newexp = {{(SUM_W - EXP_W - 1){s2_exp[EXP_W]}}, s2_exp}
                  + {{(SUM_W - SCALE_W){r1_scale[SCALE_W-1]}}, r1_scale};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
        if (en2) begin
            r2_sign    <= r1_word[WORD_W-1];
            r2_word    <= r1_word;
            r2_special <= r1_special;
            r2_cls     <= r1_cls;
            r2_frac    <= n2_frac;
            r2_newexp  <= n2_newexp;
        end
    end

    always_comb begin
        if (r2_special) begin
            n3_res = r2_word;
            n3_cls = r2_cls;
        end else if (r2_newexp >= $signed({{(SUM_W - EXP_W){1'b0}}, EXP_MAX})) begin
            n3_res = {r2_sign, EXP_MAX, {FRAC_W{1'b0}}};
            n3_cls = CLS_INF;
        end else if (r2_newexp <= $signed({SUM_W{1'b0}})) begin
            n3_res = {r2_sign, {(WORD_W - 1){1'b0}}};
            n3_cls = CLS_ZERO;
        end else begin
            n3_res = {r2_sign, r2_newexp[EXP_W-1:0], r2_frac};
            n3_cls = CLS_FINITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
        if (en3) begin
            r3_res <= n3_res;
            r3_cls <= n3_cls;
        end
    end

    assign o_out_ch.valid        = r3_valid;
    assign o_out_ch.result_bits  = r3_res;
    assign o_out_ch.result_class = r3_cls;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_ch.valid)
        else $error("output valid right after reset");

    a_finite_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.result_class == CLS_FINITE) |->
        (o_out_ch.result_bits[WORD_W-2:FRAC_W] != '0
         && o_out_ch.result_bits[WORD_W-2:FRAC_W] != EXP_MAX))
        else $error("finite word with reserved exponent");

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.result_class == CLS_ZERO) |->
        o_out_ch.result_bits[WORD_W-2:0] == '0)
        else $error("zero class with nonzero magnitude");

    a_inf_nan_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && (o_out_ch.result_class == CLS_INF
                            || o_out_ch.result_class == CLS_NAN)) |->
        (o_out_ch.result_bits[WORD_W-2:FRAC_W] == EXP_MAX
         && ((o_out_ch.result_bits[FRAC_W-1:0] != '0)
             == (o_out_ch.result_class == CLS_NAN))))
        else $error("infinity or nan class with wrong encoding");

    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && !en3) |=> (r3_valid && $stable(r3_res)))
        else $error("stalled output word changed");

endmodule
